/* sv/cpwla_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the colour pulse width to level averager.
package cpwla_pkg;

  localparam int unsigned LEVEL_W = 8;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned APB_ADDR_W = 5;
  localparam int unsigned APB_DATA_W = 32;
  localparam int unsigned REG_IDX_W = 3;
  localparam int unsigned REG_COUNT = 6;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 8'd255;
  localparam logic [31:0] CAL_LOW_RESET = 32'h0000_0000;
  localparam logic [31:0] CAL_HIGH_RESET = 32'h0000_FFFF;

  localparam logic [MODE_W-1:0] CHAN_RED = 2'd0;
  localparam logic [MODE_W-1:0] CHAN_GREEN = 2'd1;
  localparam logic [MODE_W-1:0] CHAN_BLUE = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_RED_LOW = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_RED_HIGH = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GREEN_LOW = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_GREEN_HIGH = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_BLUE_LOW = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_BLUE_HIGH = 3'd5;

  typedef struct packed {
    logic capture;
    logic commit;
    logic avg_store;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic mode_bad;
    logic div_done;
    logic avg_due;
  } status_t;

endpackage

/* sv/cpwla_div.sv */
`timescale 1ns / 1ps
// Restoring unsigned divider that produces one quotient bit per cycle.
module cpwla_div #(
  parameter int unsigned DIVIDEND_W = 24,
  parameter int unsigned DIVISOR_W = 17
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVISOR_W-1:0]  dvs_q, dvs_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;
  logic [DIVISOR_W:0]    rem_shl;
  logic [DIVISOR_W+1:0]  trial;

  assign rem_shl = {rem_q, quo_q[DIVIDEND_W-1]};
  assign trial = {1'b0, rem_shl} - {2'b00, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d = cnt_q;
    dvs_d = dvs_q;
    rem_d = rem_q;
    quo_d = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d = CNT_W'(DIVIDEND_W);
      dvs_d = divisor_i;
      rem_d = '0;
      quo_d = dividend_i;
    end else if (busy_q) begin
      cnt_d = cnt_q - CNT_W'(1);
      quo_d = {quo_q[DIVIDEND_W-2:0], ~trial[DIVISOR_W+1]};
      if (!trial[DIVISOR_W+1]) begin
        rem_d = trial[DIVISOR_W-1:0];
      end else begin
        rem_d = rem_shl[DIVISOR_W-1:0];
      end
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dvs_q <= dvs_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quotient_o = quo_q;

endmodule

/* sv/cpwla_datapath.sv */
`timescale 1ns / 1ps
// Datapath: level mapping, block sum, mapping divider, block mean and result registers.
module cpwla_datapath #(
  parameter int unsigned WIDTH_BITS = 16,
  parameter int unsigned AVERAGE_POINTS = 25
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cpwla_pkg::cmd_t                   cmd_i,
  output cpwla_pkg::status_t                status_o,
  input  logic [WIDTH_BITS-1:0]             pulse_width_i,
  input  logic [cpwla_pkg::MODE_W-1:0]      mode_i,
  input  logic [WIDTH_BITS-1:0]             cal_low_i,
  input  logic [WIDTH_BITS-1:0]             cal_high_i,
  output logic [cpwla_pkg::LEVEL_W-1:0]     level_o,
  output logic                              level_wrapped_o,
  output logic [cpwla_pkg::LEVEL_W-1:0]     average_o,
  output logic                              average_done_o
);
  import cpwla_pkg::*;

  localparam int unsigned W = WIDTH_BITS;
  localparam int unsigned N = WIDTH_BITS + 8;
  localparam int unsigned D = WIDTH_BITS + 1;
  localparam int unsigned VAL_W = N + 2;
  localparam int unsigned SUM_W = $clog2(AVERAGE_POINTS * 255 + 1);
  localparam int unsigned CNT_W = $clog2(AVERAGE_POINTS + 1);
  localparam int unsigned RECIP_SH = SUM_W + $clog2(AVERAGE_POINTS);
  localparam int unsigned RECIP_W = SUM_W + 1;
  localparam int unsigned PROD_W = RECIP_SH + LEVEL_W;
  localparam logic [RECIP_W-1:0] RECIP =
    RECIP_W'(((64'd1 << RECIP_SH) + 64'(AVERAGE_POINTS) - 64'd1) / 64'(AVERAGE_POINTS));

  logic [W:0]     diff, diff_inv;
  logic           diff_neg;
  logic [W-1:0]   diff_mag;
  logic [N-1:0]   product;
  logic [W+1:0]   dvs, dvs_inv;
  logic           dvs_neg;
  logic [D-1:0]   dvs_mag;
  logic           dvs_zero;

  logic           div_start, div_done;
  logic [N-1:0]   div_dividend, div_quo;
  logic [D-1:0]   div_divisor;

  logic [MODE_W-1:0]  mode_q;
  logic               neg_q, zero_q;
  logic [MODE_W-1:0]  chan_q;
  logic [SUM_W-1:0]   sum_q, sum_base, sum_new;
  logic [CNT_W-1:0]   cnt_q, cnt_base, cnt_new;
  logic               avg_due;

  logic [VAL_W-1:0]   quo_ext, quo_signed, value;
  logic [LEVEL_W-1:0] level_new;
  logic               wrapped_new;

  logic [SUM_W-1:0]   avg_sum_q;
  logic [PROD_W-1:0]  avg_prod;
  logic [LEVEL_W-1:0] avg_new;

  logic [LEVEL_W-1:0] lvl_q, avg_q;
  logic               wrap_q, avg_done_q;
  logic [LEVEL_W-1:0] level_q, average_q;
  logic               level_wrapped_q, average_done_q;

  // Signed mapping is done on magnitudes, with the quotient sign kept apart.
  always_comb begin
    diff = {1'b0, pulse_width_i} - {1'b0, cal_low_i};
    diff_inv = (W + 1)'(0) - diff;
    diff_neg = diff[W];
    diff_mag = diff_neg ? diff_inv[W-1:0] : diff[W-1:0];
    product = {diff_mag, 8'b0} - {7'b0, diff_mag, 1'b0};
    dvs = {2'b00, cal_high_i} + (W + 2)'(1) - {2'b00, cal_low_i};
    dvs_inv = (W + 2)'(0) - dvs;
    dvs_neg = dvs[W+1];
    dvs_mag = dvs_neg ? dvs_inv[D-1:0] : dvs[D-1:0];
    dvs_zero = (dvs == '0);
  end

  always_comb begin
    quo_ext = {2'b00, div_quo};
    quo_signed = neg_q ? (VAL_W'(0) - quo_ext) : quo_ext;
    value = VAL_W'(LEVEL_MAX) - quo_signed;
    level_new = zero_q ? LEVEL_MAX : value[LEVEL_W-1:0];
    wrapped_new = zero_q | (|value[VAL_W-1:LEVEL_W]);
  end

  always_comb begin
    if (mode_q != chan_q) begin
      sum_base = '0;
      cnt_base = '0;
    end else begin
      sum_base = sum_q;
      cnt_base = cnt_q;
    end
    sum_new = sum_base + SUM_W'(level_new);
    cnt_new = cnt_base + CNT_W'(1);
    avg_due = (cnt_new >= CNT_W'(AVERAGE_POINTS));
  end

  // The block mean is a reciprocal multiply that is exact over the whole sum range.
  assign avg_prod = PROD_W'(avg_sum_q) * PROD_W'(RECIP);
  assign avg_new = avg_prod[PROD_W-1:RECIP_SH];

  assign div_start = cmd_i.capture & ~status_o.mode_bad;
  assign div_dividend = product;
  assign div_divisor = dvs_mag;

  cpwla_div #(
    .DIVIDEND_W(N),
    .DIVISOR_W (D)
  ) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(div_dividend),
    .divisor_i (div_divisor),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  assign status_o.mode_bad = (mode_i != CHAN_RED) && (mode_i != CHAN_GREEN)
                             && (mode_i != CHAN_BLUE);
  assign status_o.div_done = div_done;
  assign status_o.avg_due = avg_due;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_q <= CHAN_RED;
      sum_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.commit) begin
      chan_q <= mode_q;
      if (avg_due) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else begin
        sum_q <= sum_new;
        cnt_q <= cnt_new;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mode_q <= mode_i;
      neg_q <= diff_neg ^ dvs_neg;
      zero_q <= dvs_zero;
      lvl_q <= '0;
      wrap_q <= 1'b0;
      avg_q <= '0;
      avg_done_q <= 1'b0;
    end
    if (cmd_i.commit) begin
      lvl_q <= level_new;
      wrap_q <= wrapped_new;
      avg_sum_q <= sum_new;
    end
    if (cmd_i.avg_store) begin
      avg_q <= avg_new;
      avg_done_q <= 1'b1;
    end
    if (cmd_i.finish) begin
      level_q <= lvl_q;
      level_wrapped_q <= wrap_q;
      average_q <= avg_q;
      average_done_q <= avg_done_q;
    end
  end

  assign level_o = level_q;
  assign level_wrapped_o = level_wrapped_q;
  assign average_o = average_q;
  assign average_done_o = average_done_q;

endmodule

/* sv/cpwla_ctrl.sv */
`timescale 1ns / 1ps
// Controller state machine that sequences one item through the datapath.
module cpwla_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 out_ready_i,
  output logic                 out_valid_o,
  input  cpwla_pkg::status_t   status_i,
  output cpwla_pkg::cmd_t      cmd_o
);
  import cpwla_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MAP = 2'd1;
  localparam logic [1:0] ST_AVG = 2'd2;
  localparam logic [1:0] ST_FIN = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = status_i.mode_bad ? ST_FIN : ST_MAP;
        end
      end
      ST_MAP: begin
        if (status_i.div_done) begin
          cmd_o.commit = 1'b1;
          state_d = status_i.avg_due ? ST_AVG : ST_FIN;
        end
      end
      ST_AVG: begin
        cmd_o.avg_store = 1'b1;
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.finish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

/* sv/colour_pulse_width_to_level_averager_unit.sv */
`timescale 1ns / 1ps
// Top level of the colour pulse width to level averager with its calibration registers.
//
//   Channel  Handshake            Payload
//   in       in_valid_i/ready_o   pulse_width_i, mode_i
//   out      out_valid_o/ready_i  level_o, level_wrapped_o, average_o, average_done_o
//   cfg      APB psel/penable     paddr, pwdata, prdata, six calibration registers
//
// A result waits on the one-bit-per-cycle divider over WIDTH_BITS + 8 quotient bits,
// then passes from ST_MAP to ST_FIN; the sample that completes a block also passes
// through ST_AVG, where the mean is stored. The next input is taken only after the
// result is finished and the controller is back in ST_IDLE, one item at a time.
// An item with an unused channel code skips the divider: ST_IDLE goes straight to ST_FIN.
// Reset restores the calibration registers and clears the block sum and count.
module colour_pulse_width_to_level_averager_unit #(
  parameter int unsigned WIDTH_BITS = 16,
  parameter int unsigned AVERAGE_POINTS = 25
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [WIDTH_BITS-1:0]               pulse_width_i,
  input  logic [cpwla_pkg::MODE_W-1:0]        mode_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [cpwla_pkg::LEVEL_W-1:0]       level_o,
  output logic                                level_wrapped_o,
  output logic [cpwla_pkg::LEVEL_W-1:0]       average_o,
  output logic                                average_done_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cpwla_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [cpwla_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [cpwla_pkg::APB_DATA_W-1:0]    prdata,
  output logic                                pready
);
  import cpwla_pkg::*;

  localparam logic [WIDTH_BITS-1:0] LOW_RST = WIDTH_BITS'(CAL_LOW_RESET);
  localparam logic [WIDTH_BITS-1:0] HIGH_RST = WIDTH_BITS'(CAL_HIGH_RESET);

  logic [WIDTH_BITS-1:0] red_low_q, red_high_q;
  logic [WIDTH_BITS-1:0] green_low_q, green_high_q;
  logic [WIDTH_BITS-1:0] blue_low_q, blue_high_q;
  logic [WIDTH_BITS-1:0] cal_low, cal_high;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic                  reg_write;
  logic [WIDTH_BITS-1:0] wdata;

  cmd_t    cmd;
  status_t status;

  assign pready = 1'b1;
  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign reg_write = psel & penable & pwrite & pready;
  assign wdata = pwdata[WIDTH_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      red_low_q <= LOW_RST;
      red_high_q <= HIGH_RST;
      green_low_q <= LOW_RST;
      green_high_q <= HIGH_RST;
      blue_low_q <= LOW_RST;
      blue_high_q <= HIGH_RST;
    end else if (reg_write) begin
      case (reg_idx)
        REG_RED_LOW: red_low_q <= wdata;
        REG_RED_HIGH: red_high_q <= wdata;
        REG_GREEN_LOW: green_low_q <= wdata;
        REG_GREEN_HIGH: green_high_q <= wdata;
        REG_BLUE_LOW: blue_low_q <= wdata;
        REG_BLUE_HIGH: blue_high_q <= wdata;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_RED_LOW: prdata = APB_DATA_W'(red_low_q);
      REG_RED_HIGH: prdata = APB_DATA_W'(red_high_q);
      REG_GREEN_LOW: prdata = APB_DATA_W'(green_low_q);
      REG_GREEN_HIGH: prdata = APB_DATA_W'(green_high_q);
      REG_BLUE_LOW: prdata = APB_DATA_W'(blue_low_q);
      REG_BLUE_HIGH: prdata = APB_DATA_W'(blue_high_q);
      default: prdata = '0;
    endcase
  end

  always_comb begin
    case (mode_i)
      CHAN_RED: begin
        cal_low = red_low_q;
        cal_high = red_high_q;
      end
      CHAN_GREEN: begin
        cal_low = green_low_q;
        cal_high = green_high_q;
      end
      CHAN_BLUE: begin
        cal_low = blue_low_q;
        cal_high = blue_high_q;
      end
      default: begin
        cal_low = '0;
        cal_high = '0;
      end
    endcase
  end

  cpwla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_ready_i(out_ready_i),
    .out_valid_o(out_valid_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  cpwla_datapath #(
    .WIDTH_BITS    (WIDTH_BITS),
    .AVERAGE_POINTS(AVERAGE_POINTS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .pulse_width_i  (pulse_width_i),
    .mode_i         (mode_i),
    .cal_low_i      (cal_low),
    .cal_high_i     (cal_high),
    .level_o        (level_o),
    .level_wrapped_o(level_wrapped_o),
    .average_o      (average_o),
    .average_done_o (average_done_o)
  );

  // A finished result never overwrites one that has not been transferred.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |-> (!out_valid_o || out_ready_i))
    else $error("result register overwritten before transfer");

  // Only one item is in flight at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken while an item is in flight");

  // The average field is zero on every result that does not close a block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !average_done_o) |-> (average_o == '0))
    else $error("average present without block completion");

  // The block mean is stored right after a committed sample that completes the block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.avg_store |-> $past(cmd.commit && status.avg_due))
    else $error("average stored without a completed block");

endmodule

/* tb/colour_pulse_width_to_level_averager_unit_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the colour pulse width to level averager with its own level predictor.
module colour_pulse_width_to_level_averager_unit_test;
  import cpwla_pkg::*;

  localparam int unsigned WIDTH_BITS = 16;
  localparam int unsigned AVERAGE_POINTS = 25;
  localparam int unsigned DRAIN_CYCLES = 2 * WIDTH_BITS + 40;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam logic [MODE_W-1:0] CHAN_UNUSED = 2'd3;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [REG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [LEVEL_W-1:0] level;
    logic               wrapped;
    logic [LEVEL_W-1:0] average;
    logic               done;
  } level_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [WIDTH_BITS-1:0] pulse_width = '0;
  logic [MODE_W-1:0]     mode = CHAN_RED;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [LEVEL_W-1:0]    level;
  logic                  level_wrapped;
  logic [LEVEL_W-1:0]    average;
  logic                  average_done;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  logic [WIDTH_BITS-1:0] cal_low [0:2];
  logic [WIDTH_BITS-1:0] cal_high [0:2];
  logic [WIDTH_BITS-1:0] next_low [0:2];
  logic [WIDTH_BITS-1:0] next_high [0:2];
  int unsigned           block_sum = 0;
  int unsigned           block_count = 0;
  logic [MODE_W-1:0]     block_channel = CHAN_RED;

  level_result_t         expected_levels[$];
  int unsigned           mismatch_count = 0;
  bit                    gaps_on = 1'b1;
  bit                    stall_request = 1'b0;

  colour_pulse_width_to_level_averager_unit #(
    .WIDTH_BITS(WIDTH_BITS),
    .AVERAGE_POINTS(AVERAGE_POINTS)
  ) dut (
    .clk_i(clk),
    .rst_ni(rst_n),
    .in_valid_i(in_valid),
    .in_ready_o(in_ready),
    .pulse_width_i(pulse_width),
    .mode_i(mode),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .level_o(level),
    .level_wrapped_o(level_wrapped),
    .average_o(average),
    .average_done_o(average_done),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #6 clk = ~clk;

  function automatic level_result_t map_level(logic [WIDTH_BITS-1:0] width,
                                              logic [MODE_W-1:0] chan);
    level_result_t r;
    longint        diff;
    longint        divisor;
    longint        value;
    r = '0;
    if (chan == CHAN_UNUSED) begin
      return r;
    end
    if (chan != block_channel) begin
      block_channel = chan;
      block_sum = 0;
      block_count = 0;
    end
    diff = longint'(width) - longint'(cal_low[chan]);
    divisor = longint'(cal_high[chan]) + 1 - longint'(cal_low[chan]);
    if (divisor == 0) begin
      value = 255;
    end else begin
      value = 255 - (diff * 254) / divisor;
    end
    r.level = value[LEVEL_W-1:0];
    r.wrapped = (divisor == 0) || (value < 0) || (value > 255);
    block_sum += r.level;
    block_count++;
    if (block_count >= AVERAGE_POINTS) begin
      r.average = LEVEL_W'(block_sum / AVERAGE_POINTS);
      r.done = 1'b1;
      block_sum = 0;
      block_count = 0;
    end
    return r;
  endfunction

  task automatic cfg_write(logic [REG_IDX_W-1:0] idx, logic [APB_DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx < REG_COUNT) begin
      if (idx[0]) begin
        cal_high[idx[2:1]] = data[WIDTH_BITS-1:0];
      end else begin
        cal_low[idx[2:1]] = data[WIDTH_BITS-1:0];
      end
    end
  endtask

  task automatic cfg_read(logic [REG_IDX_W-1:0] idx);
    logic [WIDTH_BITS-1:0] want;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    want = idx[0] ? cal_high[idx[2:1]] : cal_low[idx[2:1]];
    if (prdata[WIDTH_BITS-1:0] !== want) begin
      $display("%0t register %0d: expected %0d, got %0d", $time, idx, want,
               prdata[WIDTH_BITS-1:0]);
      mismatch_count++;
    end
    @(posedge clk);
  endtask

  task automatic cfg_release();
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic read_all_calibration();
    for (int r = REG_RED_LOW; r <= REG_BLUE_HIGH; r++) begin
      cfg_read(REG_IDX_W'(r));
    end
  endtask

  task automatic program_calibration();
    cfg_write(REG_RED_LOW, {16'd0, next_low[CHAN_RED]});
    cfg_write(REG_RED_HIGH, {16'd0, next_high[CHAN_RED]});
    cfg_write(REG_GREEN_LOW, {16'd0, next_low[CHAN_GREEN]});
    cfg_write(REG_GREEN_HIGH, {16'd0, next_high[CHAN_GREEN]});
    cfg_write(REG_BLUE_LOW, {16'd0, next_low[CHAN_BLUE]});
    cfg_write(REG_BLUE_HIGH, {16'd0, next_high[CHAN_BLUE]});
    read_all_calibration();
    cfg_release();
  endtask

  task automatic send_sample(logic [WIDTH_BITS-1:0] width, logic [MODE_W-1:0] chan);
    bit taken;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    pulse_width <= width;
    mode <= chan;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    expected_levels.push_back(map_level(width, chan));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
  endtask

  function automatic logic [WIDTH_BITS-1:0] pick_width(logic [MODE_W-1:0] chan);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return WIDTH_BITS'($urandom);
      default: return WIDTH_BITS'($urandom_range(cal_low[chan], cal_high[chan]));
    endcase
  endfunction

  task automatic send_runs(int unsigned count);
    int unsigned       sent;
    int unsigned       run;
    logic [MODE_W-1:0] chan;
    sent = 0;
    while (sent < count) begin
      chan = MODE_W'($urandom_range(CHAN_RED, CHAN_BLUE));
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 10) : $urandom_range(25, 60);
      for (int i = 0; i < run && sent < count; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_sample(pick_width(chan), CHAN_UNUSED);
        end else begin
          send_sample(pick_width(chan), chan);
        end
        sent++;
      end
    end
  endtask

  task automatic test_reset_calibration();
    read_all_calibration();
    cfg_release();
    send_sample(16'd0, CHAN_RED);
    send_sample(16'hFFFF, CHAN_RED);
    send_sample(16'h8000, CHAN_RED);
    send_sample(16'd0, CHAN_GREEN);
    send_sample(16'hFFFF, CHAN_GREEN);
    send_sample(16'd1, CHAN_BLUE);
    send_sample(16'hFFFE, CHAN_BLUE);
    send_sample(16'hFFFF, CHAN_UNUSED);
    send_sample(16'd12345, CHAN_RED);
    wait_idle();
  endtask

  task automatic test_special_calibration();
    cfg_write(REG_SPARE_A, 32'h0000_1234);
    cfg_write(REG_SPARE_B, 32'hFFFF_FFFF);
    next_low[CHAN_RED] = 16'd100;
    next_high[CHAN_RED] = 16'd99;
    next_low[CHAN_GREEN] = 16'd60000;
    next_high[CHAN_GREEN] = 16'd100;
    next_low[CHAN_BLUE] = 16'd0;
    next_high[CHAN_BLUE] = 16'd0;
    program_calibration();
    send_sample(16'd100, CHAN_RED);
    send_sample(16'd0, CHAN_RED);
    send_sample(16'hFFFF, CHAN_RED);
    send_sample(16'd0, CHAN_GREEN);
    send_sample(16'hFFFF, CHAN_GREEN);
    send_sample(16'd60000, CHAN_GREEN);
    send_sample(16'd0, CHAN_BLUE);
    send_sample(16'd1, CHAN_BLUE);
    send_sample(16'hFFFF, CHAN_BLUE);
    send_sample(16'd0, CHAN_UNUSED);
    send_sample(16'd50, CHAN_RED);
    send_sample(16'd30000, CHAN_GREEN);
    wait_idle();
  endtask

  task automatic test_block_average();
    next_low[CHAN_RED] = 16'd1000;
    next_high[CHAN_RED] = 16'd5000;
    next_low[CHAN_GREEN] = 16'd0;
    next_high[CHAN_GREEN] = 16'hFFFF;
    next_low[CHAN_BLUE] = 16'd200;
    next_high[CHAN_BLUE] = 16'd300;
    program_calibration();
    for (int i = 0; i < 25; i++) send_sample(pick_width(CHAN_RED), CHAN_RED);
    for (int i = 0; i < 10; i++) send_sample(pick_width(CHAN_GREEN), CHAN_GREEN);
    for (int i = 0; i < 30; i++) begin
      if (i % 7 == 3) begin
        send_sample(pick_width(CHAN_BLUE), CHAN_UNUSED);
      end
      send_sample(pick_width(CHAN_BLUE), CHAN_BLUE);
    end
    for (int i = 0; i < 3; i++) send_sample(pick_width(CHAN_RED), CHAN_RED);
    for (int i = 0; i < 25; i++) send_sample(pick_width(CHAN_BLUE), CHAN_BLUE);
    wait_idle();
  endtask

  task automatic test_random_phases();
    logic [WIDTH_BITS-1:0] lo;
    logic [WIDTH_BITS-1:0] hi;
    for (int phase = 0; phase < 7; phase++) begin
      for (int c = CHAN_RED; c <= CHAN_BLUE; c++) begin
        case (phase)
          0: begin lo = '0; hi = '0; end
          1: begin lo = '1; hi = '1; end
          2: begin lo = '1; hi = '0; end
          3: begin lo = '0; hi = '1; end
          default: begin
            lo = WIDTH_BITS'($urandom);
            case ($urandom_range(0, 4))
              0: hi = WIDTH_BITS'($urandom);
              1: hi = (lo > 16'hFD00) ? 16'hFFFF : lo + WIDTH_BITS'($urandom_range(0, 600));
              default: hi = WIDTH_BITS'($urandom_range(lo, 16'hFFFF));
            endcase
          end
        endcase
        next_low[MODE_W'(c)] = lo;
        next_high[MODE_W'(c)] = hi;
      end
      program_calibration();
      send_runs(110);
      wait_idle();
    end
  endtask

  task automatic test_backpressure();
    gaps_on = 1'b0;
    stall_request = 1'b1;
    send_runs(40);
    wait_idle();
    gaps_on = 1'b1;
  endtask

  task automatic test_steady_stream();
    gaps_on = 1'b0;
    send_runs(100);
    wait_idle();
  endtask

  initial begin
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    level_result_t want;
    forever begin
      @(negedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_levels.size() == 0) begin
          $display("%0t unexpected result: expected none, got level %0d", $time, level);
          mismatch_count++;
        end else begin
          want = expected_levels.pop_front();
          if (level !== want.level) begin
            $display("%0t level: expected %0d, got %0d", $time, want.level, level);
            mismatch_count++;
          end
          if (level_wrapped !== want.wrapped) begin
            $display("%0t level_wrapped: expected %0d, got %0d", $time, want.wrapped,
                     level_wrapped);
            mismatch_count++;
          end
          if (average !== want.average) begin
            $display("%0t average: expected %0d, got %0d", $time, want.average, average);
            mismatch_count++;
          end
          if (average_done !== want.done) begin
            $display("%0t average_done: expected %0d, got %0d", $time, want.done,
                     average_done);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    for (int c = CHAN_RED; c <= CHAN_BLUE; c++) begin
      cal_low[MODE_W'(c)] = CAL_LOW_RESET[WIDTH_BITS-1:0];
      cal_high[MODE_W'(c)] = CAL_HIGH_RESET[WIDTH_BITS-1:0];
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    test_reset_calibration();
    test_special_calibration();
    test_block_average();
    test_random_phases();
    test_backpressure();
    test_steady_stream();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && expected_levels.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
